// ----- design/dhfs_pkg.sv -----
// shared types and constants for the desk height framer and seeker
`timescale 1ns / 1ps

package dhfs_pkg;

	// framing
	localparam logic [7:0] END_BYTE = 8'h7E;
	localparam logic [7:0] CMD_HEIGHT = 8'd1;
	localparam logic [7:0] MAX_PARAMS = 8'd4;

	// height conversion factors and output ceiling
	localparam logic [7:0] INCH_FACTOR = 8'd254;
	localparam logic [7:0] MM_FACTOR = 8'd100;
	localparam logic [23:0] HMM_MAX = 24'd6553500;

	// actions
	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_TARGET = 2'd1;
	localparam logic [1:0] ACT_STOP = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DEADBAND = 2'd0;
	localparam logic [1:0] CFG_INCH_SPLIT = 2'd1;
	localparam logic [1:0] CFG_TARGET_MIN = 2'd2;
	localparam logic [1:0] CFG_TARGET_MAX = 2'd3;

	// event kinds passed from front to back
	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_BAD = 3'd1;
	localparam logic [2:0] EV_PKT = 3'd2;
	localparam logic [2:0] EV_HEIGHT = 3'd3;
	localparam logic [2:0] EV_TARGET = 3'd4;
	localparam logic [2:0] EV_REJECT = 3'd5;
	localparam logic [2:0] EV_STOP = 3'd6;

	typedef struct packed {
		logic [7:0]  deadband_mm;
		logic [15:0] inch_split_raw;
		logic [7:0]  target_min_cm;
		logic [7:0]  target_max_cm;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] hmm;
		logic [17:0] target_hmm;
	} event_t;

	typedef struct packed {
		logic        press_up;
		logic        press_down;
		logic [22:0] height_hmm;
		logic        height_new;
		logic        checksum_bad;
		logic        target_rejected;
		logic        seeking;
	} result_t;

endpackage

// ----- design/dhfs_fifo.sv -----
// two-entry queue used between front and back and at the result side
`timescale 1ns / 1ps

module dhfs_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- design/dhfs_front.sv -----
// front end: frame hunting, running checksum and item classification
`timescale 1ns / 1ps

module dhfs_front #(
	parameter int PACKET_BYTES = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [1:0]      action,
	input  logic [7:0]      rx_byte,
	input  logic [10:0]     target_tenths_cm,
	input  dhfs_pkg::cfg_t  cfg,
	output dhfs_pkg::event_t ev
);
	import dhfs_pkg::*;

	localparam int CNT_W = $clog2(PACKET_BYTES);
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PACKET_BYTES - 1);
	localparam logic [8:0] PKT_LEN = 9'(PACKET_BYTES);

	logic             collecting_q;
	logic [CNT_W-1:0] idx_q;
	logic [7:0]       cmd_q;
	logic [7:0]       count_q;
	logic [7:0]       hi_q;
	logic [7:0]       lo_q;
	logic [7:0]       sum_q;
	logic             match_q;
	logic [15:0]      raw_q;

	logic [8:0]  idx_ext;
	logic [8:0]  pos;
	logic        at_pos;
	logic        match_now;
	logic        pkt_ok;
	logic        last_byte;
	logic [7:0]  lo_now;
	logic [15:0] cur_raw;
	logic [7:0]  factor;
	logic [11:0] tenths_ext;
	logic [11:0] low_bound;
	logic [11:0] high_bound;
	logic        out_of_window;
	logic [2:0]  kind;

	// checksum position and packet verdict
	assign idx_ext = 9'(idx_q);
	assign pos = {1'b0, count_q} + 9'd4;
	assign at_pos = (idx_ext == pos);
	assign match_now = at_pos ? (sum_q == rx_byte) : match_q;
	assign pkt_ok = (count_q <= MAX_PARAMS) && (pos < PKT_LEN) && match_now;
	assign last_byte = collecting_q && (idx_q == LAST_IDX);
	assign lo_now = (idx_ext == 9'd5) ? rx_byte : lo_q;

	// target window in tenths of a cm
	assign tenths_ext = {1'b0, target_tenths_cm};
	assign low_bound = ({4'b0, cfg.target_min_cm} << 3) + ({4'b0, cfg.target_min_cm} << 1);
	assign high_bound = ({4'b0, cfg.target_max_cm} << 3) + ({4'b0, cfg.target_max_cm} << 1)
		+ 12'd9;
	assign out_of_window = (tenths_ext < low_bound) || (tenths_ext > high_bound);

	// classify the item
	always_comb begin
		kind = EV_NONE;
		case (action)
			ACT_BYTE: begin
				if (last_byte) begin
					if (!pkt_ok) begin
						kind = EV_BAD;
					end else if (cmd_q == CMD_HEIGHT) begin
						kind = EV_HEIGHT;
					end else begin
						kind = EV_PKT;
					end
				end
			end
			ACT_TARGET: begin
				kind = out_of_window ? EV_REJECT : EV_TARGET;
			end
			ACT_STOP: begin
				kind = EV_STOP;
			end
			default: begin
				kind = EV_NONE;
			end
		endcase
	end

	// exact height of the current report
	assign cur_raw = (kind == EV_HEIGHT) ? {hi_q, lo_now} : raw_q;
	assign factor = (cur_raw < cfg.inch_split_raw) ? INCH_FACTOR : MM_FACTOR;

	always_comb begin
		ev.kind = kind;
		ev.hmm = {8'b0, cur_raw} * {16'b0, factor};
		ev.target_hmm = {7'b0, target_tenths_cm} * 18'd100;
	end

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			idx_q <= '0;
			raw_q <= 16'd0;
		end else if (accept && action == ACT_BYTE) begin
			if (!collecting_q) begin
				if (rx_byte == END_BYTE) begin
					collecting_q <= 1'b1;
					idx_q <= '0;
				end
			end else if (last_byte) begin
				collecting_q <= 1'b0;
				idx_q <= '0;
				if (kind == EV_HEIGHT) begin
					raw_q <= cur_raw;
				end
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// packet bytes and running sum
	always_ff @(posedge clk) begin
		if (accept && action == ACT_BYTE && collecting_q) begin
			if (idx_ext == 9'd2) begin
				cmd_q <= rx_byte;
				sum_q <= rx_byte;
				match_q <= 1'b0;
			end else if (idx_ext == 9'd3) begin
				count_q <= rx_byte;
				sum_q <= sum_q + rx_byte;
			end else if (idx_ext >= 9'd4) begin
				if (idx_ext < pos) begin
					sum_q <= sum_q + rx_byte;
				end
				if (at_pos) begin
					match_q <= (sum_q == rx_byte);
				end
			end
			if (idx_ext == 9'd4) begin
				hi_q <= rx_byte;
			end
			if (idx_ext == 9'd5) begin
				lo_q <= rx_byte;
			end
		end
	end

endmodule

// ----- design/dhfs_back.sv -----
// back end: target tracking, deadband seek and result formation
`timescale 1ns / 1ps

module dhfs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ev_valid,
	input  dhfs_pkg::event_t ev,
	output logic             ev_pop,
	input  logic             res_full,
	output logic             res_push,
	output dhfs_pkg::result_t res,
	input  logic [7:0]       deadband_mm
);
	import dhfs_pkg::*;

	logic [17:0] target_hmm_q;
	logic        pending_q;
	logic        up_q;
	logic        down_q;

	logic [17:0]        target_d;
	logic               pending_d;
	logic               up_d;
	logic               down_d;
	logic [14:0]        db_hmm;
	logic signed [24:0] delta;
	logic signed [24:0] db_s;
	logic               in_band;
	logic               process;

	assign process = ev_valid && !res_full;
	assign ev_pop = process;
	assign res_push = process;

	// deadband in hundredths of a mm and distance to target
	assign db_hmm = 15'(({7'b0, deadband_mm} << 6) + ({7'b0, deadband_mm} << 5)
		+ ({7'b0, deadband_mm} << 2));
	assign db_s = $signed({10'b0, db_hmm});
	assign delta = $signed({7'b0, target_hmm_q}) - $signed({1'b0, ev.hmm});
	assign in_band = (delta < db_s) && (delta > -db_s);

	// next state for this event
	always_comb begin
		target_d = target_hmm_q;
		pending_d = pending_q;
		up_d = up_q;
		down_d = down_q;
		case (ev.kind)
			EV_PKT, EV_HEIGHT: begin
				if (pending_q) begin
					if (in_band) begin
						target_d = 18'd0;
						pending_d = 1'b0;
						up_d = 1'b0;
						down_d = 1'b0;
					end else if (delta > 25'sd0) begin
						up_d = 1'b1;
					end else begin
						down_d = 1'b1;
					end
				end
			end
			EV_TARGET: begin
				if (ev.hmm != {6'b0, ev.target_hmm}) begin
					target_d = ev.target_hmm;
					pending_d = 1'b1;
				end
			end
			EV_STOP: begin
				target_d = 18'd0;
				pending_d = 1'b0;
				up_d = 1'b0;
				down_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// result fields
	always_comb begin
		res.press_up = up_d;
		res.press_down = down_d;
		res.height_hmm = (ev.hmm > HMM_MAX) ? HMM_MAX[22:0] : ev.hmm[22:0];
		res.height_new = (ev.kind == EV_HEIGHT);
		res.checksum_bad = (ev.kind == EV_BAD);
		res.target_rejected = (ev.kind == EV_REJECT);
		res.seeking = pending_d;
	end

	// seek state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_hmm_q <= 18'd0;
			pending_q <= 1'b0;
			up_q <= 1'b0;
			down_q <= 1'b0;
		end else if (process) begin
			target_hmm_q <= target_d;
			pending_q <= pending_d;
			up_q <= up_d;
			down_q <= down_d;
		end
	end

endmodule

// ----- design/desk_height_frame_and_seek.sv -----
// Desk height frame hunter and target seeker, top level.
// Path: an item is held in the event queue, its result in the result queue.
// Throughput: one item per cycle while the result queue has room; the front
// classifier and back seek decision are combinational, with two-entry queues between.
// Reset: asynchronous active-low; hunting for the end byte, no target,
// both button lines released, registers at their documented defaults.
`timescale 1ns / 1ps

module desk_height_frame_and_seek #(
	parameter int PACKET_BYTES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [7:0]  rx_byte,
	input  logic [10:0] target_tenths_cm,
	output logic        empty,
	input  logic        pop,
	output logic        press_up,
	output logic        press_down,
	output logic [22:0] height_hmm,
	output logic        height_new,
	output logic        checksum_bad,
	output logic        target_rejected,
	output logic        seeking,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import dhfs_pkg::*;

	cfg_t    cfg_q;
	event_t  ev_in;
	event_t  ev_out;
	result_t res_in;
	result_t res_out;
	logic    accept;
	logic    ev_empty;
	logic    ev_pop;
	logic    res_full;
	logic    res_push;

	assign accept = push && !full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband_mm <= 8'd10;
			cfg_q.inch_split_raw <= 16'd600;
			cfg_q.target_min_cm <= 8'd62;
			cfg_q.target_max_cm <= 8'd127;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEADBAND: cfg_q.deadband_mm <= cfg_data[7:0];
				CFG_INCH_SPLIT: cfg_q.inch_split_raw <= cfg_data;
				CFG_TARGET_MIN: cfg_q.target_min_cm <= cfg_data[7:0];
				CFG_TARGET_MAX: cfg_q.target_max_cm <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// framing and classification
	dhfs_front #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.action(action),
		.rx_byte(rx_byte),
		.target_tenths_cm(target_tenths_cm),
		.cfg(cfg_q),
		.ev(ev_in)
	);

	// event queue between front and back
	dhfs_fifo #(
		.WIDTH($bits(event_t))
	) u_ev_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.wdata(ev_in),
		.full(full),
		.pop(ev_pop),
		.rdata(ev_out),
		.empty(ev_empty)
	);

	// seek and result formation
	dhfs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ev_valid(!ev_empty),
		.ev(ev_out),
		.ev_pop(ev_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in),
		.deadband_mm(cfg_q.deadband_mm)
	);

	// result queue
	dhfs_fifo #(
		.WIDTH($bits(result_t))
	) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.rdata(res_out),
		.empty(empty)
	);

	// result ports
	assign press_up = res_out.press_up;
	assign press_down = res_out.press_down;
	assign height_hmm = res_out.height_hmm;
	assign height_new = res_out.height_new;
	assign checksum_bad = res_out.checksum_bad;
	assign target_rejected = res_out.target_rejected;
	assign seeking = res_out.seeking;

endmodule
